/* rtl/core/bundle_block_crc_check_top_assert.svh */
// ----------------------------------------------------------------------------
// bundle_block_crc_check_top_assert.svh
// Assertion macros shared by the CRC check RTL.
// ----------------------------------------------------------------------------
`ifndef BUNDLE_BLOCK_CRC_CHECK_TOP_ASSERT_SVH
`define BUNDLE_BLOCK_CRC_CHECK_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clock, quiet during reset.
`define BBCC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, quiet during reset.
`define BBCC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bbcc_pkg.sv */
// ----------------------------------------------------------------------------
// bbcc_pkg
// Types, constants and CRC helpers for the block CRC field check.
// ----------------------------------------------------------------------------
`default_nettype none

package bbcc_pkg;

   // CRC kind codes of the configuration register
   localparam logic [1:0] KIND_X25    = 2'd1;
   localparam logic [1:0] KIND_CRC32C = 2'd2;

   // Reflected polynomials and accumulator preset
   localparam logic [15:0] POLY_X25_REFL    = 16'h8408;
   localparam logic [31:0] POLY_CRC32C_REFL = 32'h82F6_3B78;
   localparam logic [31:0] ACC_INIT         = 32'hFFFF_FFFF;

   // Tail delay line: newest four bytes, count saturates at four
   localparam int          TAIL_DEPTH = 4;
   localparam logic [2:0]  CNT_FULL   = 3'd4;
   localparam logic [1:0]  IDX_TOP    = 2'd3;

   // Snapshot of one finished block, walked through the fold stages
   typedef struct packed {
      logic [31:0]                      acc;
      logic [TAIL_DEPTH-1:0][7:0]       held;
      logic [2:0]                       cnt;
      logic [1:0]                       kind;
      logic [1:0]                       idx;
      logic [31:0]                      received;
   } fin_type;

   // Fold one byte into the accumulator with the given kind
   function automatic logic [31:0] crc_fold_byte(input logic [31:0] acc,
                                                 input logic [1:0]  kind,
                                                 input logic [7:0]  data);
      logic [31:0] a;
      logic [15:0] h;
      a = acc;
      h = acc[15:0];
      if (kind == KIND_X25) begin
         h = h ^ {8'h00, data};
         for (int i = 0; i < 8; i++) begin
            h = h[0] ? ((h >> 1) ^ POLY_X25_REFL) : (h >> 1);
         end
         a = {16'h0000, h};
      end else if (kind == KIND_CRC32C) begin
         a = a ^ {24'h000000, data};
         for (int i = 0; i < 8; i++) begin
            a = a[0] ? ((a >> 1) ^ POLY_CRC32C_REFL) : (a >> 1);
         end
      end
      return a;
   endfunction

   // Length of the embedded CRC field in bytes; zero means no check
   function automatic logic [2:0] field_len(input logic [1:0] kind);
      logic [2:0] len;
      len = 3'd0;
      if (kind == KIND_X25) begin
         len = 3'd2;
      end else if (kind == KIND_CRC32C) begin
         len = 3'd4;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/bbcc_fold_stage.sv */
// ----------------------------------------------------------------------------
// bbcc_fold_stage
// One registered finishing stage: folds the held byte at the snapshot's
// current index (zero inside the CRC field) and steps the index down.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcc_fold_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire bbcc_pkg::fin_type in_word,
   output logic                  in_ready,
   output logic                  out_valid,
   output bbcc_pkg::fin_type     out_word,
   input  wire logic             out_ready
);

   logic              valid_ff;
   logic              valid_in;
   bbcc_pkg::fin_type word_ff;
   bbcc_pkg::fin_type word_in;
   logic [2:0]        flen;
   logic [7:0]        tap;

   // stage moves when empty or when downstream takes its word
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // fold the byte at idx if it belongs to the block; field bytes count as zero
   always_comb begin
      flen    = bbcc_pkg::field_len(in_word.kind);
      tap     = ({1'b0, in_word.idx} < flen) ? 8'h00 : in_word.held[in_word.idx];
      word_in = in_word;
      if ({1'b0, in_word.idx} < in_word.cnt) begin
         word_in.acc = bbcc_pkg::crc_fold_byte(in_word.acc, in_word.kind, tap);
      end
      word_in.idx = in_word.idx - 2'd1;
      valid_in    = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bundle_block_crc_check_top.sv */
// Path: fold stage 0 loads at the edge that accepts the last byte of a block,
//   then the word passes three more fold stages and the result register in
//   order; back-pressure from rsp_tready can hold it in any of them.
// Throughput: one byte per cycle while fold stage 0 can take a word; the byte-wide
//   CRC update on the tail delay line and one byte fold per finishing stage set that figure.
// Reset (synchronous, active high): CRC kind none, accumulator all ones,
//   tail bytes and count zero, pipeline and result word empty.
`default_nettype none
// ----------------------------------------------------------------------------
// bundle_block_crc_check_top
// Checks the big-endian CRC field at the tail of a byte stream block
// (CRC-16/X-25 or CRC-32C) against the CRC computed with that field zeroed.
// ----------------------------------------------------------------------------

module bundle_block_crc_check_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_wdata,     // crc_kind
   // byte stream in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [7:0] data_byte
   input  wire logic        req_tlast,     // last_byte
   // check result out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,     // [31:0] computed_crc, [63:32] received_crc
   output logic [1:0]       rsp_tuser      // [0] crc_ok, [1] too_short
);

   localparam int NUM_STAGES = 4;

   // block state
   logic [1:0]                          kind_ff;
   logic [31:0]                         acc_ff;
   logic [bbcc_pkg::TAIL_DEPTH-1:0][7:0] held_ff;
   logic [2:0]                          cnt_ff;

   logic [31:0]                         acc_step;
   logic [bbcc_pkg::TAIL_DEPTH-1:0][7:0] held_step;
   logic [2:0]                          cnt_step;
   logic                                req_accept;

   // finishing pipeline
   logic                                stg_valid [0:NUM_STAGES];
   logic                                stg_ready [0:NUM_STAGES];
   bbcc_pkg::fin_type                   stg_word  [0:NUM_STAGES];

   // result register
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [63:0]                         rsp_data_ff;
   logic [63:0]                         rsp_data_in;
   logic [1:0]                          rsp_user_ff;
   logic [1:0]                          rsp_user_in;
   logic                                rsp_load;
   logic [2:0]                          fin_len;
   logic [31:0]                         fin_crc;

   // block state back at its preset
   logic                                blk_clear;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = stg_ready[0];

   // oldest held byte leaves the full delay line and is folded with the current kind
   always_comb begin
      acc_step  = (cnt_ff == bbcc_pkg::CNT_FULL) ?
                  bbcc_pkg::crc_fold_byte(acc_ff, kind_ff, held_ff[3]) : acc_ff;
      held_step = {held_ff[2:0], req_tdata};
      cnt_step  = (cnt_ff == bbcc_pkg::CNT_FULL) ? cnt_ff : cnt_ff + 3'd1;
   end

   // snapshot of the block on its last byte
   always_comb begin
      stg_valid[0]          = req_tvalid && req_tlast;
      stg_word[0].acc       = acc_step;
      stg_word[0].held      = held_step;
      stg_word[0].cnt       = cnt_step;
      stg_word[0].kind      = kind_ff;
      stg_word[0].idx       = bbcc_pkg::IDX_TOP;
      stg_word[0].received  = 32'h0;
      if (kind_ff == bbcc_pkg::KIND_X25) begin
         stg_word[0].received = {16'h0000, held_step[1], held_step[0]};
      end else if (kind_ff == bbcc_pkg::KIND_CRC32C) begin
         stg_word[0].received = held_step;
      end
   end

   // configuration register and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 2'd0;
         acc_ff  <= bbcc_pkg::ACC_INIT;
         held_ff <= '0;
         cnt_ff  <= 3'd0;
      end else begin
         if (csr_we) begin
            kind_ff <= csr_wdata;
         end
         if (req_accept) begin
            if (req_tlast) begin
               acc_ff  <= bbcc_pkg::ACC_INIT;
               held_ff <= '0;
               cnt_ff  <= 3'd0;
            end else begin
               acc_ff  <= acc_step;
               held_ff <= held_step;
               cnt_ff  <= cnt_step;
            end
         end
      end
   end

   // fold stages: positions 3 down to 0 of the tail, one per stage
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_fold
      bbcc_fold_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[g]),
         .in_word   (stg_word[g]),
         .in_ready  (stg_ready[g]),
         .out_valid (stg_valid[g+1]),
         .out_word  (stg_word[g+1]),
         .out_ready (stg_ready[g+1])
      );
   end

   // finish, compare and build the result word
   always_comb begin
      fin_len     = bbcc_pkg::field_len(stg_word[NUM_STAGES].kind);
      fin_crc     = ~stg_word[NUM_STAGES].acc;
      if (stg_word[NUM_STAGES].kind == bbcc_pkg::KIND_X25) begin
         fin_crc = {16'h0000, ~stg_word[NUM_STAGES].acc[15:0]};
      end
      rsp_data_in = 64'h0;
      rsp_user_in = 2'b01;
      if (fin_len == 3'd0) begin
         rsp_user_in = 2'b01;
      end else if (stg_word[NUM_STAGES].cnt < fin_len) begin
         rsp_user_in = 2'b10;
      end else begin
         rsp_data_in = {stg_word[NUM_STAGES].received, fin_crc};
         rsp_user_in = {1'b0, fin_crc == stg_word[NUM_STAGES].received};
      end
   end

   assign stg_ready[NUM_STAGES] = !rsp_valid_ff || rsp_tready;
   assign rsp_load              = stg_ready[NUM_STAGES] && stg_valid[NUM_STAGES];
   assign rsp_valid_in          = stg_ready[NUM_STAGES] ? stg_valid[NUM_STAGES]
                                                        : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   assign blk_clear = (cnt_ff == 3'd0) && (acc_ff == bbcc_pkg::ACC_INIT);

`include "bundle_block_crc_check_top_assert.svh"

   `BBCC_ASSERT_IMP(a_short_not_ok, rsp_tvalid, !(rsp_tuser[1] && rsp_tuser[0]), "short ok")
   `BBCC_ASSERT_IMP(a_short_zero, rsp_tvalid && rsp_tuser[1], rsp_tdata == 64'h0, "short CRCs")
   `BBCC_ASSERT_NXT(a_clear_on_last, req_accept && req_tlast, blk_clear, "state kept")
   `BBCC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_ff <= bbcc_pkg::CNT_FULL, "count past four")

endmodule

`default_nettype wire
